/* rtl/core/i2cm_pkg.sv */
// Shared constants, codes and types of the I2C register-access sequencer.
package i2cm_pkg;

    localparam int QUEUE_DEPTH = 64;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int ENTRY_W     = 15;

    localparam logic [1:0] FUNC_RD     = 2'd0;
    localparam logic [1:0] FUNC_WR     = 2'd1;
    localparam logic [1:0] FUNC_EV     = 2'd2;
    localparam logic [1:0] FUNC_UNUSED = 2'd3;

    localparam logic [1:0] STS_OK      = 2'd0;
    localparam logic [1:0] STS_WR_BUSY = 2'd1;
    localparam logic [1:0] STS_RD_DROP = 2'd2;

    typedef struct packed {
        logic [1:0] func;
        logic [6:0] dev_addr;
        logic [7:0] reg_num;
        logic [7:0] wr_val;
        logic       ev_start_sent;
        logic       ev_addr_sent;
        logic       ev_tx_empty;
        logic       ev_byte_done;
        logic       ev_rx_full;
        logic       ev_other;
        logic [7:0] rx_in;
    } t_in_item;

    typedef struct packed {
        logic [1:0] req_status;
        logic       busy_res;
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic       gen_start;
        logic       gen_stop;
        logic       ack_off;
        logic       rx_valid;
        logic [7:0] rx_byte;
        logic       evt_irq_en;
        logic       buf_irq_en;
    } t_res_item;

    typedef struct packed {
        logic               push;
        logic               pop;
        logic [ENTRY_W-1:0] wentry;
    } t_q_req;

    typedef struct packed {
        logic               empty;
        logic               full;
        logic [ENTRY_W-1:0] head;
    } t_q_sts;

endpackage

/* rtl/core/i2cm_if.sv */
// Valid/ready channel interfaces for request/event words and result words.
interface i2cm_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] func;
    logic [6:0] dev_addr;
    logic [7:0] reg_num;
    logic [7:0] wr_val;
    logic       ev_start_sent;
    logic       ev_addr_sent;
    logic       ev_tx_empty;
    logic       ev_byte_done;
    logic       ev_rx_full;
    logic       ev_other;
    logic [7:0] rx_in;

    modport source (
        output valid, func, dev_addr, reg_num, wr_val, ev_start_sent, ev_addr_sent,
               ev_tx_empty, ev_byte_done, ev_rx_full, ev_other, rx_in,
        input  ready
    );
    modport sink (
        input  valid, func, dev_addr, reg_num, wr_val, ev_start_sent, ev_addr_sent,
               ev_tx_empty, ev_byte_done, ev_rx_full, ev_other, rx_in,
        output ready
    );
endinterface

interface i2cm_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] req_status;
    logic       busy_res;
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       gen_start;
    logic       gen_stop;
    logic       ack_off;
    logic       rx_valid;
    logic [7:0] rx_byte;
    logic       evt_irq_en;
    logic       buf_irq_en;

    modport source (
        output valid, req_status, busy_res, tx_valid, tx_byte, gen_start, gen_stop,
               ack_off, rx_valid, rx_byte, evt_irq_en, buf_irq_en,
        input  ready
    );
    modport sink (
        input  valid, req_status, busy_res, tx_valid, tx_byte, gen_start, gen_stop,
               ack_off, rx_valid, rx_byte, evt_irq_en, buf_irq_en,
        output ready
    );
endinterface

/* rtl/core/i2cm_ram.sv */
// Generic simple dual-port RAM, one write port, one registered read port.
module i2cm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

/* rtl/core/i2cm_rdq.sv */
// Read-request queue: RAM-backed FIFO with the head entry always presented.
module i2cm_rdq (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  i2cm_pkg::t_q_req i_req,
    output i2cm_pkg::t_q_sts o_sts
);
    import i2cm_pkg::*;

    logic [QPTR_W-1:0]  r_head, n_head;
    logic [QPTR_W-1:0]  r_tail, n_tail;
    logic [QCNT_W-1:0]  r_count;
    logic               r_byp;
    logic [ENTRY_W-1:0] r_byp_data;
    logic [ENTRY_W-1:0] ram_rdata;

    function automatic logic [QPTR_W-1:0] f_next(input logic [QPTR_W-1:0] p);
        return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign n_head = i_req.pop  ? f_next(r_head) : r_head;
    assign n_tail = i_req.push ? f_next(r_tail) : r_tail;

    // read address follows the next head; a write to it this cycle is bypassed
    i2cm_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_req.push),
        .i_waddr (r_tail),
        .i_wdata (i_req.wentry),
        .i_raddr (n_head),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
            r_byp   <= 1'b0;
        end else begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= r_count + QCNT_W'(i_req.push) - QCNT_W'(i_req.pop);
            r_byp   <= i_req.push && (r_tail == n_head);
        end
        r_byp_data <= i_req.wentry;
    end

    assign o_sts.empty = (r_count == '0);
    assign o_sts.full  = (r_count >= QCNT_W'(QUEUE_DEPTH));
    assign o_sts.head  = r_byp ? r_byp_data : ram_rdata;
endmodule

/* rtl/core/i2cm_seq.sv */
// Transfer sequencer: transfer state and the per-word decision logic.
module i2cm_seq (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_adv,
    input  i2cm_pkg::t_in_item  i_item,
    input  i2cm_pkg::t_q_sts    i_q_sts,
    output i2cm_pkg::t_q_req    o_q_req,
    output i2cm_pkg::t_res_item o_res
);
    import i2cm_pkg::*;

    logic       r_mode_wr, n_mode_wr;
    logic       r_addr_done, n_addr_done;
    logic       r_busy, n_busy;
    logic [6:0] r_dev, n_dev;
    logic [7:0] r_reg, n_reg;
    logic [7:0] r_data, n_data;
    logic       r_left, n_left;
    logic       r_evt_en, n_evt_en;
    logic       r_buf_en, n_buf_en;

    t_res_item          res;
    t_q_req             qreq;
    logic               try_start;
    logic [ENTRY_W-1:0] pop_entry;
    logic               txe_only;

    assign txe_only = i_item.ev_tx_empty && !i_item.ev_start_sent && !i_item.ev_addr_sent
                      && !i_item.ev_byte_done && !i_item.ev_rx_full && !i_item.ev_other;

    always_comb begin
        n_mode_wr   = r_mode_wr;
        n_addr_done = r_addr_done;
        n_busy      = r_busy;
        n_dev       = r_dev;
        n_reg       = r_reg;
        n_data      = r_data;
        n_left      = r_left;
        n_evt_en    = r_evt_en;
        n_buf_en    = r_buf_en;
        res         = '0;
        qreq        = '0;
        qreq.wentry = {i_item.dev_addr, i_item.reg_num};
        try_start   = 1'b0;

        unique case (i_item.func)
            FUNC_RD: begin
                if (i_q_sts.full) begin
                    res.req_status = STS_RD_DROP;
                end else begin
                    qreq.push = 1'b1;
                end
                try_start = 1'b1;
            end
            FUNC_WR: begin
                if (r_busy) begin
                    res.req_status = STS_WR_BUSY;
                end else begin
                    n_busy        = 1'b1;
                    n_dev         = i_item.dev_addr;
                    n_reg         = i_item.reg_num;
                    n_data        = i_item.wr_val;
                    n_mode_wr     = 1'b1;
                    n_left        = 1'b1;
                    n_addr_done   = 1'b0;
                    n_evt_en      = 1'b1;
                    res.gen_start = 1'b1;
                end
            end
            FUNC_EV: begin
                if (r_evt_en) begin
                    if (!r_addr_done) begin
                        if (i_item.ev_start_sent) begin
                            res.tx_valid = 1'b1;
                            res.tx_byte  = {r_dev, 1'b0};
                        end
                        if (i_item.ev_addr_sent) begin
                            n_addr_done  = 1'b1;
                            n_buf_en     = 1'b1;
                            res.tx_valid = 1'b1;
                            res.tx_byte  = r_reg;
                        end
                    end else if (r_mode_wr) begin
                        if (i_item.ev_tx_empty && r_left) begin
                            res.tx_valid = 1'b1;
                            res.tx_byte  = r_data;
                            n_left       = 1'b0;
                            n_buf_en     = 1'b0;
                        end
                        if (i_item.ev_byte_done && !n_left) begin
                            n_evt_en     = 1'b0;
                            res.gen_stop = 1'b1;
                            n_busy       = 1'b0;
                            try_start    = 1'b1;
                        end
                    end else if (!txe_only) begin
                        if (i_item.ev_byte_done) begin
                            res.gen_start = 1'b1;
                        end
                        if (i_item.ev_start_sent) begin
                            res.tx_valid = 1'b1;
                            res.tx_byte  = {r_dev, 1'b1};
                            res.ack_off  = 1'b1;
                        end
                        if (i_item.ev_addr_sent) begin
                            res.gen_stop = 1'b1;
                        end
                        if (i_item.ev_rx_full) begin
                            n_evt_en     = 1'b0;
                            n_buf_en     = 1'b0;
                            n_data       = i_item.rx_in;
                            res.rx_valid = 1'b1;
                            res.rx_byte  = i_item.rx_in;
                            n_busy       = 1'b0;
                            try_start    = 1'b1;
                        end
                    end
                end
            end
            default: begin
            end
        endcase

        // an empty queue can only pop the word pushed in this same step
        pop_entry = i_q_sts.empty ? qreq.wentry : i_q_sts.head;
        if (try_start && !n_busy && (!i_q_sts.empty || qreq.push)) begin
            qreq.pop      = 1'b1;
            n_busy        = 1'b1;
            n_dev         = pop_entry[14:8];
            n_reg         = pop_entry[7:0];
            n_mode_wr     = 1'b0;
            n_left        = 1'b1;
            n_addr_done   = 1'b0;
            n_evt_en      = 1'b1;
            res.gen_start = 1'b1;
        end

        res.busy_res   = n_busy;
        res.evt_irq_en = n_evt_en;
        res.buf_irq_en = n_buf_en;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode_wr   <= 1'b0;
            r_addr_done <= 1'b0;
            r_busy      <= 1'b0;
            r_dev       <= '0;
            r_reg       <= '0;
            r_data      <= '0;
            r_left      <= 1'b0;
            r_evt_en    <= 1'b0;
            r_buf_en    <= 1'b0;
        end else if (i_adv) begin
            r_mode_wr   <= n_mode_wr;
            r_addr_done <= n_addr_done;
            r_busy      <= n_busy;
            r_dev       <= n_dev;
            r_reg       <= n_reg;
            r_data      <= n_data;
            r_left      <= n_left;
            r_evt_en    <= n_evt_en;
            r_buf_en    <= n_buf_en;
        end
    end

    assign o_q_req.push   = qreq.push && i_adv;
    assign o_q_req.pop    = qreq.pop && i_adv;
    assign o_q_req.wentry = qreq.wentry;
    assign o_res          = res;
endmodule

/* rtl/core/i2c_master_register_access_sequencer_core.sv */
// I2C master register-access sequencer, top level: word registers and block wiring.
// Each request or bus-event word gives exactly one result word. A word goes through
// an input register, the decision logic and a result register, so the block takes one
// word per clock while the output register is free or its result is taken; a stalled result
// holds only the input register behind it. Read requests wait in a 64-entry queue
// held in RAM; a read dropped on a full queue is flagged with status 2, and a write
// that arrives while a transfer runs is refused with status 1. The queue needs no
// clearing pass after reset.
module i2c_master_register_access_sequencer_core (
    input  logic i_clk,
    input  logic i_rst_n,
    i2cm_in_if.sink    i_in,
    i2cm_out_if.source o_out
);
    import i2cm_pkg::*;

    logic      r_iv;
    t_in_item  r_item;
    logic      r_ov;
    t_res_item r_res;
    logic      adv;
    t_res_item res;
    t_q_req    q_req;
    t_q_sts    q_sts;

    assign adv        = r_iv && (!r_ov || o_out.ready);
    assign i_in.ready = !r_iv || adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iv <= 1'b0;
            r_ov <= 1'b0;
        end else begin
            if (i_in.ready) begin
                r_iv <= i_in.valid;
            end
            if (adv) begin
                r_ov <= 1'b1;
            end else if (o_out.ready) begin
                r_ov <= 1'b0;
            end
        end
        if (i_in.ready && i_in.valid) begin
            r_item.func          <= i_in.func;
            r_item.dev_addr      <= i_in.dev_addr;
            r_item.reg_num       <= i_in.reg_num;
            r_item.wr_val        <= i_in.wr_val;
            r_item.ev_start_sent <= i_in.ev_start_sent;
            r_item.ev_addr_sent  <= i_in.ev_addr_sent;
            r_item.ev_tx_empty   <= i_in.ev_tx_empty;
            r_item.ev_byte_done  <= i_in.ev_byte_done;
            r_item.ev_rx_full    <= i_in.ev_rx_full;
            r_item.ev_other      <= i_in.ev_other;
            r_item.rx_in         <= i_in.rx_in;
        end
        if (adv) begin
            r_res <= res;
        end
    end

    i2cm_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_item  (r_item),
        .i_q_sts (q_sts),
        .o_q_req (q_req),
        .o_res   (res)
    );

    i2cm_rdq u_rdq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (q_req),
        .o_sts   (q_sts)
    );

    assign o_out.valid      = r_ov;
    assign o_out.req_status = r_res.req_status;
    assign o_out.busy_res   = r_res.busy_res;
    assign o_out.tx_valid   = r_res.tx_valid;
    assign o_out.tx_byte    = r_res.tx_byte;
    assign o_out.gen_start  = r_res.gen_start;
    assign o_out.gen_stop   = r_res.gen_stop;
    assign o_out.ack_off    = r_res.ack_off;
    assign o_out.rx_valid   = r_res.rx_valid;
    assign o_out.rx_byte    = r_res.rx_byte;
    assign o_out.evt_irq_en = r_res.evt_irq_en;
    assign o_out.buf_irq_en = r_res.buf_irq_en;

`ifndef NO_ASSERTIONS
    a_busy_reject: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.req_status == STS_WR_BUSY) |-> o_out.busy_res)
        else $error("write refused while bus reported idle");

    a_rx_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.rx_valid && !o_out.gen_start) |-> !o_out.busy_res)
        else $error("read finished without start but still busy");

    a_ackoff_tx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.ack_off) |-> (o_out.tx_valid && o_out.tx_byte[0]))
        else $error("ack off without read address byte");

    a_tx_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.tx_valid) |-> (o_out.tx_byte == 8'd0))
        else $error("tx byte not cleared");
`endif
endmodule
